@@ sv/rdat_pkg.sv @@
// Shared types and constants for the datagram ack tracker.
`timescale 1ns / 1ps
`default_nettype none

package rdat_pkg;

    // Fixed sizes of the scheme.
    localparam int HIST_LEN    = 32;
    localparam int MAX_RESULTS = 16;
    localparam logic [31:0] INTERVAL_RESET = 32'd1000;

    // Operation codes of an input item.
    localparam logic [1:0] OP_SEND_UNREL = 2'd0;
    localparam logic [1:0] OP_SEND_REL   = 2'd1;
    localparam logic [1:0] OP_RECEIVE    = 2'd2;
    localparam logic [1:0] OP_TICK       = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_SEND    = 3'd0;
    localparam logic [2:0] KIND_RESEND  = 3'd1;
    localparam logic [2:0] KIND_RX_OK   = 3'd2;
    localparam logic [2:0] KIND_RX_REJ  = 3'd3;
    localparam logic [2:0] KIND_DROPPED = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] rx_sequence;
        logic [31:0] rx_ack;
        logic [31:0] rx_ack_mask;
        logic [15:0] packet_tag;
        logic [31:0] now;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] tx_sequence;
        logic [31:0] tx_ack;
        logic [31:0] tx_ack_mask;
        logic [15:0] resend_tag;
        logic        last;
    } t_out_item;

    // One pending reliable packet.
    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] stamp;
        logic [15:0] tag;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MASK,
        S_SEND,
        S_DROP,
        S_REJECT,
        S_RX_RD,
        S_RX_EV,
        S_RX_DONE,
        S_TK_RD,
        S_TK_EV,
        S_TK_FLUSH
    } t_state;

endpackage

`default_nettype wire

@@ sv/reliable_datagram_ack_tracker.sv @@
// Sequence and ack-mask reliability engine for one datagram connection.
// A send builds the ack mask one history slot a cycle, then emits its result.
// A dropped reliable send or a rejected receive goes straight to its result. An accepted receive
// reads each pending entry in turn, one compare per entry. A tick builds the ack
// mask, then scans the pending entries unless the table is empty; results may add stalls.
// One item at a time; synchronous active-low reset clears sequences, history,
// table fill count and the interval (to 1000). No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module reliable_datagram_ack_tracker
    import rdat_pkg::*;
#(
    parameter int PENDING_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);

    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);
    localparam logic [4:0] K_MAX = 5'(MAX_RESULTS);

    t_state      r_state, n_state;
    t_in_item    r_item, n_item;
    logic [31:0] r_local, n_local;
    logic [31:0] r_remote, n_remote;
    logic [31:0] r_hist [HIST_LEN];
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_wr, n_wr;
    logic [4:0]  r_bit, n_bit;
    logic [31:0] r_cmp, n_cmp;
    logic [31:0] r_mask, n_mask;
    logic [4:0]  r_k, n_k;
    logic        r_held, n_held;
    logic [31:0] r_held_seq, n_held_seq;
    logic [15:0] r_held_tag, n_held_tag;
    logic [31:0] r_interval;
    logic        r_out_valid;
    t_out_item   r_out;
    t_entry      r_rd;
    t_entry      mem [PENDING_DEPTH];

    logic        out_free;
    logic        hist_shift;
    logic        emit;
    t_out_item   emit_item;
    logic        mem_we;
    logic [AW-1:0] mem_wa;
    t_entry      mem_wd;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // Sequencer: next state, emitted result and table write.
    always_comb begin
        logic [31:0] ack_dist;
        logic [31:0] age;
        logic        hit;
        logic        due;
        logic        last_entry;
        n_state    = r_state;
        n_item     = r_item;
        n_local    = r_local;
        n_remote   = r_remote;
        n_count    = r_count;
        n_idx      = r_idx;
        n_wr       = r_wr;
        n_bit      = r_bit;
        n_cmp      = r_cmp;
        n_mask     = r_mask;
        n_k        = r_k;
        n_held     = r_held;
        n_held_seq = r_held_seq;
        n_held_tag = r_held_tag;
        hist_shift = 1'b0;
        emit       = 1'b0;
        emit_item  = '0;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = '0;
        ack_dist   = r_item.rx_ack - r_rd.seq;
        hit        = (ack_dist[31:5] == 27'd0) && r_item.rx_ack_mask[ack_dist[4:0]];
        age        = r_item.now - r_rd.stamp;
        due        = (age > r_interval) && (r_k < K_MAX);
        last_entry = ((r_idx + CW'(1)) == r_count);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in;
                    n_bit  = '0;
                    n_cmp  = r_remote;
                    n_mask = '0;
                    n_idx  = '0;
                    n_wr   = '0;
                    n_k    = '0;
                    unique case (i_in.operation)
                        OP_SEND_UNREL: n_state = S_MASK;
                        OP_SEND_REL: begin
                            n_state = (r_count == DEPTH_C) ? S_DROP : S_MASK;
                        end
                        OP_RECEIVE: begin
                            if (i_in.rx_sequence > r_remote || r_remote == 32'd0) begin
                                n_remote   = i_in.rx_sequence;
                                hist_shift = 1'b1;
                                n_state    = (r_count == '0) ? S_RX_DONE : S_RX_RD;
                            end else begin
                                n_state = S_REJECT;
                            end
                        end
                        OP_TICK: n_state = S_MASK;
                    endcase
                end
            end
            // One history slot per cycle against remote minus the bit index.
            S_MASK: begin
                n_mask[r_bit] = (r_hist[~r_bit] == r_cmp);
                n_cmp = r_cmp - 32'd1;
                n_bit = r_bit + 5'd1;
                if (r_bit == 5'd31) begin
                    if (r_item.operation == OP_TICK) begin
                        n_state = (r_count == '0) ? S_IDLE : S_TK_RD;
                    end else begin
                        n_state = S_SEND;
                    end
                end
            end
            S_SEND: begin
                if (out_free) begin
                    emit                  = 1'b1;
                    emit_item.kind        = KIND_SEND;
                    emit_item.tx_sequence = r_local;
                    emit_item.tx_ack      = r_remote;
                    emit_item.tx_ack_mask = r_mask;
                    emit_item.resend_tag  = (r_item.operation == OP_SEND_REL) ?
                                            r_item.packet_tag : 16'd0;
                    emit_item.last        = 1'b1;
                    n_local               = r_local + 32'd1;
                    if (r_item.operation == OP_SEND_REL) begin
                        mem_we       = 1'b1;
                        mem_wa       = r_count[AW-1:0];
                        mem_wd.seq   = r_local;
                        mem_wd.stamp = r_item.now;
                        mem_wd.tag   = r_item.packet_tag;
                        n_count      = r_count + CW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            S_DROP: begin
                if (out_free) begin
                    emit                 = 1'b1;
                    emit_item.kind       = KIND_DROPPED;
                    emit_item.resend_tag = r_item.packet_tag;
                    emit_item.last       = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            S_REJECT: begin
                if (out_free) begin
                    emit           = 1'b1;
                    emit_item.kind = KIND_RX_REJ;
                    emit_item.last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_RX_RD: n_state = S_RX_EV;
            // Drop acknowledged entries and close up the survivors in order.
            S_RX_EV: begin
                if (!hit) begin
                    mem_we = 1'b1;
                    mem_wa = r_wr[AW-1:0];
                    mem_wd = r_rd;
                    n_wr   = r_wr + CW'(1);
                end
                n_idx = r_idx + CW'(1);
                if (last_entry) begin
                    n_count = hit ? r_wr : (r_wr + CW'(1));
                    n_state = S_RX_DONE;
                end else begin
                    n_state = S_RX_RD;
                end
            end
            S_RX_DONE: begin
                if (out_free) begin
                    emit           = 1'b1;
                    emit_item.kind = KIND_RX_OK;
                    emit_item.last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_TK_RD: n_state = S_TK_EV;
            // A due entry is held back one step so the final one can carry last.
            S_TK_EV: begin
                if (!(due && r_held && !out_free)) begin
                    if (due) begin
                        if (r_held) begin
                            emit                  = 1'b1;
                            emit_item.kind        = KIND_RESEND;
                            emit_item.tx_sequence = r_held_seq;
                            emit_item.tx_ack      = r_remote;
                            emit_item.tx_ack_mask = r_mask;
                            emit_item.resend_tag  = r_held_tag;
                        end
                        n_held       = 1'b1;
                        n_held_seq   = r_local;
                        n_held_tag   = r_rd.tag;
                        mem_we       = 1'b1;
                        mem_wa       = r_idx[AW-1:0];
                        mem_wd.seq   = r_local;
                        mem_wd.stamp = r_item.now;
                        mem_wd.tag   = r_rd.tag;
                        n_local      = r_local + 32'd1;
                        n_k          = r_k + 5'd1;
                    end
                    n_idx   = r_idx + CW'(1);
                    n_state = last_entry ? S_TK_FLUSH : S_TK_RD;
                end
            end
            S_TK_FLUSH: begin
                if (!r_held) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    emit                  = 1'b1;
                    emit_item.kind        = KIND_RESEND;
                    emit_item.tx_sequence = r_held_seq;
                    emit_item.tx_ack      = r_remote;
                    emit_item.tx_ack_mask = r_mask;
                    emit_item.resend_tag  = r_held_tag;
                    emit_item.last        = 1'b1;
                    n_held                = 1'b0;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, history and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_local     <= '0;
            r_remote    <= '0;
            r_count     <= '0;
            r_held      <= 1'b0;
            r_out_valid <= 1'b0;
            r_interval  <= INTERVAL_RESET;
            for (int j = 0; j < HIST_LEN; j++) begin
                r_hist[j] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_local  <= n_local;
            r_remote <= n_remote;
            r_count  <= n_count;
            r_held   <= n_held;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_interval <= i_cfg_data;
            end
            if (hist_shift) begin
                for (int j = 0; j < HIST_LEN - 1; j++) begin
                    r_hist[j] <= r_hist[j+1];
                end
                r_hist[HIST_LEN-1] <= n_remote;
            end
        end
    end

    // Working registers and the output item.
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_idx      <= n_idx;
        r_wr       <= n_wr;
        r_bit      <= n_bit;
        r_cmp      <= n_cmp;
        r_mask     <= n_mask;
        r_k        <= n_k;
        r_held_seq <= n_held_seq;
        r_held_tag <= n_held_tag;
        if (emit) begin
            r_out <= emit_item;
        end
    end

    // Pending table: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (r_state == S_RX_RD || r_state == S_TK_RD) begin
            r_rd <= mem[r_idx[AW-1:0]];
        end
    end

    // Fill count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("pending count exceeds depth");

    // An accepted item always starts work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted item did not start");

    // A held resend exists only during a tick scan.
    a_held_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_state == S_TK_RD || r_state == S_TK_EV || r_state == S_TK_FLUSH))
        else $error("held resend outside tick");

    // Resends per tick stay within the cap.
    a_k_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TK_EV) |-> (r_k <= K_MAX))
        else $error("too many resends in one tick");

endmodule

`default_nettype wire
